>>> sv/context_ready_round_robin_scheduler_defines.svh
`ifndef CONTEXT_READY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define CONTEXT_READY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// Condition must never hold outside reset.
`define CRRS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("scheduler check failed: forbidden condition");

// Implication within the same cycle.
`define CRRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed: implication");

// Implication in the next cycle.
`define CRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed: next-cycle implication");

`endif

>>> sv/crrs_pkg.sv
`timescale 1ns / 1ps

package crrs_pkg;

    localparam int NUM_CTX = 32;
    localparam int CTX_W   = $clog2(NUM_CTX);
    localparam int IDX_W   = 5;
    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 3;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 8;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [ADDR_W-1:0] REG_LL_MASK_ADDR = ADDR_W'(0);

    typedef enum logic [1:0] {
        ACT_SET       = 2'd0,
        ACT_CLEAR     = 2'd1,
        ACT_PICK_NEW  = 2'd2,
        ACT_PICK_NEXT = 2'd3
    } t_action;

    localparam logic [1:0] KIND_DEC = 2'd0;
    localparam logic [1:0] KIND_ENC = 2'd1;

    localparam logic [3:0] ST_GOT_INST    = 4'd0;
    localparam logic [3:0] ST_RUNNING     = 4'd1;
    localparam logic [3:0] ST_FINISHING   = 4'd2;
    localparam logic [3:0] ST_HEAD_PARSED = 4'd3;
    localparam logic [3:0] ST_RES_INIT    = 4'd4;
    localparam logic [3:0] ST_RES_FLUSH   = 4'd5;
    localparam logic [3:0] ST_RES_END     = 4'd6;
    localparam logic [3:0] ST_ABORT       = 4'd7;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_FIN  = 1'b1
    } t_bk_state;

    typedef struct packed {
        t_action            action;
        logic [CTX_W-1:0]   ctx_idx;
        logic               ready;
        logic               wr_en;
        logic [CTX_W-1:0]   cur_idx;
        logic               pre_valid;
        logic [IDX_W-1:0]   pre_idx;
    } t_cmd;

    typedef struct packed {
        logic               busy;
        logic               done;
    } t_bk_status;

    typedef struct packed {
        logic               found;
        logic [CTX_W-1:0]   idx;
    } t_find;

    function automatic t_find find_first(input logic [NUM_CTX-1:0] vec);
        t_find res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = NUM_CTX - 1; i >= 0; i--) begin
            if (vec[i]) begin
                res.found = 1'b1;
                res.idx   = CTX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

>>> sv/crrs_front.sv
`timescale 1ns / 1ps

module crrs_front
    import crrs_pkg::*;
(
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IN_W-1:0]   i_data,   // ctx_idx, kind, state, no_wait, src, dst, hdr,
                                        // down, cur_idx, pre_valid, pre_idx (lowest first)
    input  logic [1:0]        i_user,   // action
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [4:0] ctx_idx;
    logic [1:0] kind;
    logic [3:0] state;
    logic       no_wait;
    logic       src;
    logic       dst;
    logic       hdr;
    logic       down;
    logic [4:0] cur_idx;
    logic       pre_valid;
    logic [4:0] pre_idx;
    logic       dec_rdy;
    logic       enc_rdy;
    logic       known;
    logic       rdy;
    t_action    action;

    assign ctx_idx   = i_data[4:0];
    assign kind      = i_data[6:5];
    assign state     = i_data[10:7];
    assign no_wait   = i_data[11];
    assign src       = i_data[12];
    assign dst       = i_data[13];
    assign hdr       = i_data[14];
    assign down      = i_data[15];
    assign cur_idx   = i_data[20:16];
    assign pre_valid = i_data[21];
    assign pre_idx   = i_data[26:22];
    assign action    = t_action'(i_user);

    always_comb begin
        case (state)
            ST_GOT_INST:    dec_rdy = src;
            ST_RUNNING:     dec_rdy = no_wait && src && dst;
            ST_FINISHING:   dec_rdy = dst;
            ST_HEAD_PARSED: dec_rdy = dst && no_wait;
            ST_RES_INIT:    dec_rdy = dst;
            ST_RES_FLUSH:   dec_rdy = dst;
            ST_RES_END:     dec_rdy = src;
            default:        dec_rdy = 1'b0;
        endcase
    end

    always_comb begin
        case (state)
            ST_GOT_INST:    enc_rdy = dst && (!hdr || src);
            ST_HEAD_PARSED: enc_rdy = dst;
            ST_RUNNING:     enc_rdy = src && dst;
            ST_ABORT:       enc_rdy = src && dst;
            ST_FINISHING:   enc_rdy = src && dst;
            default:        enc_rdy = 1'b0;
        endcase
    end

    assign known = ((kind == KIND_DEC) || (kind == KIND_ENC)) && !down;
    assign rdy   = known && ((kind == KIND_DEC) ? dec_rdy : enc_rdy);

    always_comb begin
        o_cmd.action    = action;
        o_cmd.ctx_idx   = CTX_W'(ctx_idx);
        o_cmd.ready     = rdy;
        o_cmd.wr_en     = 1'b0;
        o_cmd.cur_idx   = CTX_W'(cur_idx);
        o_cmd.pre_valid = pre_valid;
        o_cmd.pre_idx   = pre_idx;
        case (action)
            ACT_SET:   o_cmd.wr_en = known && (int'(ctx_idx) < NUM_CTX) && rdy;
            ACT_CLEAR: o_cmd.wr_en = known && (int'(ctx_idx) < NUM_CTX) && !rdy;
            default:   o_cmd.wr_en = 1'b0;
        endcase
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

>>> sv/crrs_queue.sv
`timescale 1ns / 1ps

module crrs_queue
    import crrs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_PTR_W-1:0]  n_wr_ptr;
    logic [Q_PTR_W-1:0]  n_rd_ptr;
    logic [Q_CNT_W-1:0]  n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> sv/crrs_back.sv
`timescale 1ns / 1ps

module crrs_back
    import crrs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_cmd                i_q_cmd,
    output logic                o_pop,
    input  logic [NUM_CTX-1:0]  i_ll_mask,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OUT_W-1:0]    o_data,   // ready_flag, grant_valid, grant_index
    output t_bk_status          o_status
);

    t_bk_state           r_state;
    t_bk_state           n_state;
    t_cmd                r_cmd;
    logic [NUM_CTX-1:0]  r_rot;
    logic [CTX_W-1:0]    r_start;
    logic                r_ll_hit;
    logic [CTX_W-1:0]    r_ll_idx;
    logic [NUM_CTX-1:0]  r_ready_bits;
    logic                r_out_valid;
    logic                r_out_ready;
    logic                r_out_gv;
    logic [IDX_W-1:0]    r_out_gi;

    logic                out_free;
    logic                pop;
    logic                done;
    logic [CTX_W-1:0]    start;
    logic [2*NUM_CTX-1:0] dbl;
    logic [NUM_CTX-1:0]  rot;
    t_find               ll_find;
    t_find               rr_find;
    logic [CTX_W:0]      rr_sum;
    logic [CTX_W-1:0]    rr_idx;
    logic                res_gv;
    logic [IDX_W-1:0]    res_gi;
    logic                is_pick;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        case (r_state)
            BK_IDLE: n_state = i_q_valid ? BK_FIN : BK_IDLE;
            BK_FIN:  n_state = out_free ? BK_IDLE : BK_FIN;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        pop  = 1'b0;
        done = 1'b0;
        case (r_state)
            BK_IDLE: pop  = i_q_valid;
            BK_FIN:  done = out_free;
            default: begin
                pop  = 1'b0;
                done = 1'b0;
            end
        endcase
    end

    assign o_pop           = pop;
    assign o_status.busy   = (r_state == BK_FIN);
    assign o_status.done   = done;

    // rotate so that bit 0 is the context just after the current one
    assign start   = (i_q_cmd.cur_idx == CTX_W'(NUM_CTX - 1)) ? '0 : i_q_cmd.cur_idx + 1'b1;
    assign dbl     = {r_ready_bits, r_ready_bits} >> start;
    assign ll_find = find_first(i_ll_mask);

    always_comb begin
        rot = dbl[NUM_CTX-1:0];
        if (i_q_cmd.action == ACT_PICK_NEXT) begin
            rot[NUM_CTX-1] = 1'b0;
        end
    end

    assign rr_find = find_first(r_rot);
    assign rr_sum  = {1'b0, r_start} + {1'b0, rr_find.idx};
    assign rr_idx  = (rr_sum >= (CTX_W + 1)'(NUM_CTX)) ?
                     CTX_W'(rr_sum - (CTX_W + 1)'(NUM_CTX)) : CTX_W'(rr_sum);

    assign is_pick = (r_cmd.action == ACT_PICK_NEW) || (r_cmd.action == ACT_PICK_NEXT);

    always_comb begin
        res_gv = 1'b0;
        res_gi = '0;
        case (r_cmd.action)
            ACT_PICK_NEW: begin
                if (r_cmd.pre_valid) begin
                    res_gv = 1'b1;
                    res_gi = r_cmd.pre_idx;
                end else if (r_ll_hit) begin
                    res_gv = 1'b1;
                    res_gi = IDX_W'(r_ll_idx);
                end else if (rr_find.found) begin
                    res_gv = 1'b1;
                    res_gi = IDX_W'(rr_idx);
                end
            end
            ACT_PICK_NEXT: begin
                if (rr_find.found) begin
                    res_gv = 1'b1;
                    res_gi = IDX_W'(rr_idx);
                end
            end
            default: begin
                res_gv = 1'b0;
                res_gi = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_ready_bits <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done && r_cmd.wr_en) begin
                r_ready_bits[r_cmd.ctx_idx] <= r_cmd.ready;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd    <= i_q_cmd;
            r_rot    <= rot;
            r_start  <= start;
            r_ll_hit <= ll_find.found && r_ready_bits[ll_find.idx];
            r_ll_idx <= ll_find.idx;
        end
        if (done) begin
            r_out_ready <= !is_pick && r_cmd.ready;
            r_out_gv    <= res_gv;
            r_out_gi    <= res_gi;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {{(OUT_W - IDX_W - 2){1'b0}}, r_out_gi, r_out_gv, r_out_ready};

endmodule

>>> sv/context_ready_round_robin_scheduler.sv
// Context ready scheduler with round-robin pick. Each item on the slave stream
// is either a ready update (set or clear of one context's ready bit, with the
// readiness worked out from kind, state and queue flags) or a pick (new or
// next) that returns the granted context. Every item gives exactly one result
// item on the master stream, in order. A two-entry command queue sits between
// the classifying front end and the executing back end; the back end handles
// one item at a time (in its idle state it pops the queue and registers the
// rotated ready bits, then in its finish state it priority-finds and writes
// the one-entry output register, waiting there while the output is stalled).
// low_latency_mask is register 0 at byte address 0.
`timescale 1ns / 1ps
`include "context_ready_round_robin_scheduler_defines.svh"

module context_ready_round_robin_scheduler
    import crrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_W-1:0]    s_axis_tdata,   // context_index, context_kind, context_state,
                                               // waiting_none, source_pending, dest_pending,
                                               // header_needs_source, shutting_down,
                                               // current_index, preempt_valid, preempt_index
    input  logic [1:0]         s_axis_tuser,   // action
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // ready_flag, grant_valid, grant_index
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready
);

    logic [CFG_W-1:0]  r_ll_mask;
    logic              q_full;
    logic              q_push;
    t_cmd              q_in_cmd;
    logic              q_valid;
    t_cmd              q_out_cmd;
    logic              q_pop;
    t_bk_status        bk_status;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_LL_MASK_ADDR) ? r_ll_mask : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ll_mask <= '0;
        end else if (psel && penable && pwrite && pready && (paddr == REG_LL_MASK_ADDR)) begin
            r_ll_mask <= pwdata;
        end
    end

    crrs_front u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_user   (s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in_cmd)
    );

    crrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    crrs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_out_cmd),
        .o_pop     (q_pop),
        .i_ll_mask (r_ll_mask[NUM_CTX-1:0]),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_status  (bk_status)
    );

    `CRRS_ASSERT_NEVER(a_flag_and_grant, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[1])
    `CRRS_ASSERT_IMPL(a_no_grant_zero_idx, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tdata[1], m_axis_tdata[6:2] == '0)
    `CRRS_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !bk_status.done, !m_axis_tvalid)
    `CRRS_ASSERT_IMPL(a_pop_only_idle, i_clk, i_rst_n,
        q_pop, !bk_status.busy && q_valid)

endmodule
